>>> rtl/spi_clock_divisor_search_unit_assert.svh
// Assertion macros for the serial clock divisor search unit.
`ifndef SPI_CLOCK_DIVISOR_SEARCH_UNIT_ASSERT_SVH
`define SPI_CLOCK_DIVISOR_SEARCH_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scds assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SCDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scds assertion failed");

`endif

>>> rtl/scds_pkg.sv
// Package with constants and types of the serial clock divisor search unit.
`timescale 1ns / 1ps

package scds_pkg;

  // Field widths
  localparam int unsigned CLK_W   = 30;
  localparam int unsigned SPEED_W = 27;
  localparam int unsigned BITS_W  = 5;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned PRE_W   = 8;
  localparam int unsigned OVS_W   = 29;
  localparam int unsigned CTL_W   = 16;
  localparam int unsigned IN_W    = 32;
  localparam int unsigned OUT_W   = 64;

  // Search limits
  localparam logic [DIV_W-1:0] RATE_DIV_MAX = 8'd255;
  localparam int unsigned      HALF_W       = 7;
  localparam logic [HALF_W-1:0] HALF_MAX    = 7'd127;
  localparam logic [HALF_W-1:0] HALF_MIN    = 7'd1;

  // Register reset value and saturation limit
  localparam logic [CLK_W-1:0] CLK_RESET     = 30'd100000000;
  localparam logic [CLK_W-1:0] OVERSHOOT_SAT = 30'h1FFF_FFFF;

  // Counter width for the bit-serial quotient loops
  localparam int unsigned CNT_W = 5;

  typedef logic [CLK_W-1:0] clk_hz_t;

endpackage

>>> rtl/spi_clock_divisor_search_unit.sv
// Serial clock divisor search unit: best rate divider and even prescaler for a bit rate.
`timescale 1ns / 1ps

// One request takes a requested bit rate and a frame width and returns one result.
// The target half divisor comes from a restoring divider that yields one quotient bit
// per cycle, followed by a step that rounds it up. Divider values 0 to 255 are then
// tried in order: each gets a range check, and a value in range adds a prescale half
// division and an evaluation. The search ends early at the first exact pair. A new
// request is taken only while no search runs; a finished result waits in the output
// register while the next request is accepted.
module spi_clock_divisor_search_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration: input clock frequency in hertz
  input  logic                        cfg_wr_en,
  input  logic [scds_pkg::CLK_W-1:0]  cfg_wr_data,
  // Request: [26:0] speed_hz, [31:27] data_bits
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [scds_pkg::IN_W-1:0]   in_tdata,
  // Result: [7:0] rate_divider, [15:8] prescale, [44:16] overshoot,
  // [60:45] control_word, [61] exact_match, [63:62] zero
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [scds_pkg::OUT_W-1:0]  out_tdata
);

  import scds_pkg::*;

  `include "spi_clock_divisor_search_unit_assert.svh"

  typedef enum logic [2:0] {
    IDLE_S, TDIV_S, TFIN_S, TRY_S, HDIV_S, EVAL_S, FIN_S
  } state_t;

  state_t             state_r;
  clk_hz_t            clk_hz_r;
  logic [BITS_W-1:0]  bits_r;
  logic [CNT_W-1:0]   cnt_r;

  // Target division registers
  logic [SPEED_W:0]   tdiv_r;
  logic [CLK_W-1:0]   tq_r;
  logic [SPEED_W:0]   trem_r;
  clk_hz_t            target_r;

  // Trial registers
  logic [DIV_W-1:0]   d_r;
  logic [DIV_W-1:0]   hrem_r;
  logic [HALF_W-1:0]  hq_r;

  // Best pair so far
  clk_hz_t            least_err_r;
  logic [DIV_W-1:0]   best_d_r;
  logic [HALF_W-1:0]  best_h_r;

  // Result register
  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_tdata_r;

  // Request fields
  logic [SPEED_W-1:0] in_speed;
  logic [BITS_W-1:0]  in_bits;
  logic [SPEED_W-1:0] speed_fix;

  assign in_speed  = in_tdata[SPEED_W-1:0];
  assign in_bits   = in_tdata[SPEED_W +: BITS_W];
  assign speed_fix = (in_speed == '0) ? SPEED_W'(1) : in_speed;

  // One step of the target division
  logic [SPEED_W+1:0] trem_sh;
  logic               t_ge;
  logic [SPEED_W+1:0] trem_sub;

  assign trem_sh  = {trem_r, tq_r[CLK_W-1]};
  assign t_ge     = trem_sh >= {1'b0, tdiv_r};
  assign trem_sub = trem_sh - {1'b0, tdiv_r};

  // Trial divisor d + 1 and the largest target it can serve
  logic [DIV_W:0]     m;
  logic [15:0]        lim;
  logic               out_of_range;

  assign m            = {1'b0, d_r} + (DIV_W+1)'(1);
  assign lim          = {m, 7'b0} - {7'b0, m};
  assign out_of_range = target_r > {14'b0, lim};

  // One step of the prescale half division
  logic [DIV_W:0]     hrem_sh;
  logic               h_ge;
  logic [DIV_W:0]     hrem_sub;

  assign hrem_sh  = {hrem_r, hq_r[HALF_W-1]};
  assign h_ge     = hrem_sh >= m;
  assign hrem_sub = hrem_sh - m;

  // Rounded-up prescale half and its excess over the target
  logic [HALF_W-1:0]  h_val;
  logic [DIV_W:0]     e_val;

  always_comb begin
    if (hrem_r != '0) begin
      h_val = hq_r + HALF_W'(1);
      e_val = m - {1'b0, hrem_r};
    end else if (hq_r == '0) begin
      h_val = HALF_MIN;
      e_val = m;
    end else begin
      h_val = hq_r;
      e_val = '0;
    end
  end

  logic               e_better;
  assign e_better = {21'b0, e_val} < least_err_r;

  // Packed result
  logic [OVS_W-1:0]   ovs;
  logic [3:0]         ctl_bits;
  logic [CTL_W-1:0]   ctl_word;
  logic [OUT_W-1:0]   result;

  assign ovs      = (least_err_r > OVERSHOOT_SAT) ? OVERSHOOT_SAT[OVS_W-1:0]
                                                  : least_err_r[OVS_W-1:0];
  assign ctl_bits = bits_r[3:0] - 4'd1;
  assign ctl_word = {best_d_r, 1'b1, 1'b0, 2'b00, ctl_bits};
  assign result   = {2'b00, (least_err_r == '0), ctl_word, ovs,
                     {best_h_r, 1'b0}, best_d_r};

  // Sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE_S;
      out_tvalid_r <= 1'b0;
      clk_hz_r     <= CLK_RESET;
      cnt_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        clk_hz_r <= cfg_wr_data;
      end
      // In the final state the result load below decides the flag.
      if (out_tvalid_r && out_tready && state_r != FIN_S) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE_S: begin
          if (in_tvalid) begin
            tdiv_r  <= {speed_fix, 1'b0};
            tq_r    <= clk_hz_r;
            trem_r  <= '0;
            bits_r  <= in_bits;
            cnt_r   <= '0;
            state_r <= TDIV_S;
          end
        end
        TDIV_S: begin
          trem_r <= t_ge ? trem_sub[SPEED_W:0] : trem_sh[SPEED_W:0];
          tq_r   <= {tq_r[CLK_W-2:0], t_ge};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(CLK_W - 1)) begin
            state_r <= TFIN_S;
          end
        end
        TFIN_S: begin
          target_r    <= tq_r + {29'b0, (trem_r != '0)};
          least_err_r <= tq_r + {29'b0, (trem_r != '0)};
          best_d_r    <= RATE_DIV_MAX;
          best_h_r    <= HALF_MAX;
          d_r         <= '0;
          state_r     <= TRY_S;
        end
        TRY_S: begin
          if (out_of_range) begin
            if (d_r == RATE_DIV_MAX) begin
              state_r <= FIN_S;
            end else begin
              d_r <= d_r + DIV_W'(1);
            end
          end else begin
            hrem_r  <= target_r[14:7];
            hq_r    <= target_r[6:0];
            cnt_r   <= '0;
            state_r <= HDIV_S;
          end
        end
        HDIV_S: begin
          hrem_r <= h_ge ? hrem_sub[DIV_W-1:0] : hrem_sh[DIV_W-1:0];
          hq_r   <= {hq_r[HALF_W-2:0], h_ge};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(HALF_W - 1)) begin
            state_r <= EVAL_S;
          end
        end
        EVAL_S: begin
          if (e_better) begin
            least_err_r <= {21'b0, e_val};
            best_d_r    <= d_r;
            best_h_r    <= h_val;
          end
          if ((e_better && e_val == '0) || d_r == RATE_DIV_MAX) begin
            state_r <= FIN_S;
          end else begin
            d_r     <= d_r + DIV_W'(1);
            state_r <= TRY_S;
          end
        end
        FIN_S: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= result;
            out_tvalid_r <= 1'b1;
            state_r      <= IDLE_S;
          end
        end
        default: begin
          state_r <= IDLE_S;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == IDLE_S);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A taken request starts a search, so no second transfer follows at once.
  `SCDS_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)
  // An exact result carries zero overshoot.
  `SCDS_ASSERT_NOW(a_exact_zero, out_tvalid && out_tdata[61], out_tdata[44:16] == '0)
  // The running best never exceeds the target during the search.
  `SCDS_ASSERT_NOW(a_best_bound, state_r == EVAL_S, least_err_r <= target_r)
  // A trial division only runs for a target inside the prescale range.
  `SCDS_ASSERT_NOW(a_trial_range, state_r == HDIV_S, !out_of_range)

endmodule
